// ===== hw/rtl/yuyvbgr_pkg.sv =====
// shared types and constants of the yuyv to bgr24 converter
package yuyvbgr_pkg;

   localparam int PIX_W   = 8;
   localparam int DIFF_W  = PIX_W + 1;
   localparam int Q_SHIFT = 12;
   localparam int SUM_W   = 22;
   localparam int CLIP_W  = SUM_W - Q_SHIFT;
   localparam int COEF_W  = 14;

   // signed q12 coefficients, rounded to nearest
   localparam logic signed [COEF_W-1:0] K_RCR = 14'sd5761;
   localparam logic signed [COEF_W-1:0] K_GCB = 14'sd1415;
   localparam logic signed [COEF_W-1:0] K_GCR = 14'sd2936;
   localparam logic signed [COEF_W-1:0] K_BCB = 14'sd7287;

   localparam logic [PIX_W-1:0] CHROMA_MID = 8'd128;
   localparam logic [PIX_W-1:0] PIX_MAX    = 8'd255;

   typedef struct packed {
      logic [PIX_W-1:0] luma_first;
      logic [PIX_W-1:0] chroma_blue;
      logic [PIX_W-1:0] luma_second;
      logic [PIX_W-1:0] chroma_red;
      logic             frame_end_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue_first;
      logic [PIX_W-1:0] green_first;
      logic [PIX_W-1:0] red_first;
      logic [PIX_W-1:0] blue_second;
      logic [PIX_W-1:0] green_second;
      logic [PIX_W-1:0] red_second;
      logic             frame_end_out;
   } rsp_type;

   // stage 1: luma and centered chroma
   typedef struct packed {
      logic [PIX_W-1:0]         luma0;
      logic [PIX_W-1:0]         luma1;
      logic signed [DIFF_W-1:0] db;
      logic signed [DIFF_W-1:0] dr;
      logic                     last;
   } st1_type;

   // stage 2: chroma products
   typedef struct packed {
      logic [PIX_W-1:0]        luma0;
      logic [PIX_W-1:0]        luma1;
      logic signed [SUM_W-1:0] p_b;
      logic signed [SUM_W-1:0] p_gb;
      logic signed [SUM_W-1:0] p_gr;
      logic signed [SUM_W-1:0] p_r;
      logic                    last;
   } st2_type;

   // stage 3: floored channel values before clamping
   typedef struct packed {
      logic signed [CLIP_W-1:0] b0;
      logic signed [CLIP_W-1:0] g0;
      logic signed [CLIP_W-1:0] r0;
      logic signed [CLIP_W-1:0] b1;
      logic signed [CLIP_W-1:0] g1;
      logic signed [CLIP_W-1:0] r1;
      logic                     last;
   } st3_type;

endpackage

// ===== hw/rtl/yuyv_to_bgr24_converter_unit.sv =====
// yuyv macropixel to two bgr24 pixels, four-stage pipeline
// a request enters stage one at its accept edge and moves through the stages in order
// (chroma center, multiply, add and floor, clamp into the output register)
// throughput: one request per cycle while the output is not stalled; each stage loads when empty or when the
// stage after it moves, so a stalled output backs up without loss
// reset: synchronous, active high, clears the stage valid bits only
module yuyv_to_bgr24_converter_unit
   import yuyvbgr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    v1_ff, v2_ff, v3_ff, v4_ff;
   logic    v1_in, v2_in, v3_in, v4_in;
   logic    en1, en2, en3, en4;
   st1_type s1_ff, s1_in;
   st2_type s2_ff, s2_in;
   st3_type s3_ff, s3_in;
   rsp_type s4_ff, s4_in;

   logic signed [SUM_W-1:0] base0, base1;
   logic signed [SUM_W-1:0] sb0, sg0, sr0, sb1, sg1, sr1;

   function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [CLIP_W-1:0] v);
      logic [PIX_W-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > $signed({{(CLIP_W-PIX_W){1'b0}}, PIX_MAX})) begin
         res = PIX_MAX;
      end else begin
         res = v[PIX_W-1:0];
      end
      return res;
   endfunction

   // load enables ripple back from the output
   assign en4 = !v4_ff || rsp_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_ready = en1;
   assign rsp_valid = v4_ff;
   assign rsp_data  = s4_ff;

   assign v1_in = en1 ? req_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;
   assign v4_in = en4 ? v3_ff : v4_ff;

   always_comb begin
      s1_in.luma0 = req_data.luma_first;
      s1_in.luma1 = req_data.luma_second;
      s1_in.db    = $signed({1'b0, req_data.chroma_blue}) - $signed({1'b0, CHROMA_MID});
      s1_in.dr    = $signed({1'b0, req_data.chroma_red}) - $signed({1'b0, CHROMA_MID});
      s1_in.last  = req_data.frame_end_in;
   end

   always_comb begin
      s2_in.luma0 = s1_ff.luma0;
      s2_in.luma1 = s1_ff.luma1;
      s2_in.p_b   = SUM_W'(K_BCB * s1_ff.db);
      s2_in.p_gb  = SUM_W'(K_GCB * s1_ff.db);
      s2_in.p_gr  = SUM_W'(K_GCR * s1_ff.dr);
      s2_in.p_r   = SUM_W'(K_RCR * s1_ff.dr);
      s2_in.last  = s1_ff.last;
   end

   // upper bits of the sum are the floor of sum / 4096
   always_comb begin
      base0 = $signed({{(SUM_W-PIX_W-Q_SHIFT){1'b0}}, s2_ff.luma0, {Q_SHIFT{1'b0}}});
      base1 = $signed({{(SUM_W-PIX_W-Q_SHIFT){1'b0}}, s2_ff.luma1, {Q_SHIFT{1'b0}}});
      sb0   = base0 + s2_ff.p_b;
      sg0   = base0 - s2_ff.p_gb - s2_ff.p_gr;
      sr0   = base0 + s2_ff.p_r;
      sb1   = base1 + s2_ff.p_b;
      sg1   = base1 - s2_ff.p_gb - s2_ff.p_gr;
      sr1   = base1 + s2_ff.p_r;
      s3_in.b0   = sb0[SUM_W-1:Q_SHIFT];
      s3_in.g0   = sg0[SUM_W-1:Q_SHIFT];
      s3_in.r0   = sr0[SUM_W-1:Q_SHIFT];
      s3_in.b1   = sb1[SUM_W-1:Q_SHIFT];
      s3_in.g1   = sg1[SUM_W-1:Q_SHIFT];
      s3_in.r1   = sr1[SUM_W-1:Q_SHIFT];
      s3_in.last = s2_ff.last;
   end

   always_comb begin
      s4_in.blue_first    = clamp_pix(s3_ff.b0);
      s4_in.green_first   = clamp_pix(s3_ff.g0);
      s4_in.red_first     = clamp_pix(s3_ff.r0);
      s4_in.blue_second   = clamp_pix(s3_ff.b1);
      s4_in.green_second  = clamp_pix(s3_ff.g1);
      s4_in.red_second    = clamp_pix(s3_ff.r1);
      s4_in.frame_end_out = s3_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff <= s1_in;
      end
      if (en2) begin
         s2_ff <= s2_in;
      end
      if (en3) begin
         s3_ff <= s3_in;
      end
      if (en4) begin
         s4_ff <= s4_in;
      end
   end

   // full pipe with a stalled output takes no new request
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && v4_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while pipeline full and stalled");

   // a held stage keeps its item
   a_hold_s2: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !en2) |=> (v2_ff && $stable(s2_ff)))
      else $error("stage two lost an item during stall");

   // an item moving into the output register shows up as a response
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && en4) |=> rsp_valid)
      else $error("item lost on the way to the output");

   // negative blue of the first pixel clamps to zero
   a_clamp_low: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && en4 && s3_ff.b0 < 0) |=> (rsp_data.blue_first == '0))
      else $error("negative blue not clamped to zero");

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench of the yuyv to bgr24 converter: directed table, then random pixels
`timescale 1ns / 1ps

module testbench
   import yuyvbgr_pkg::*;
();

   localparam int Q12_RED_CR   = 5761;
   localparam int Q12_GREEN_CB = 1415;
   localparam int Q12_GREEN_CR = 2936;
   localparam int Q12_BLUE_CB  = 7287;
   localparam int RANDOM_PER_PHASE = 350;
   localparam int HOLD_CYCLES      = 60;
   localparam int DRAIN_CYCLES     = 8;
   localparam int STALL_LIMIT      = 4000;

   typedef struct packed {
      req_type pixels;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type pending_bgr[$];
   int      errors = 0;
   int      stall_cycles = 0;
   int      send_idle_pct = 24;
   int      recv_idle_pct = 65;
   bit      hold_off_request = 1'b0;

   // typed expectations only where the answer is plain: neutral chroma passes luma through
   stim_row_type directed_rows [17] = '{
      '{'{8'd0,   8'd128, 8'd255, 8'd128, 1'b0}, 1'b1,
        '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0}},
      '{'{8'd255, 8'd128, 8'd0,   8'd128, 1'b1}, 1'b1,
        '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1}},
      '{'{8'd17,  8'd128, 8'd200, 8'd128, 1'b0}, 1'b1,
        '{8'd17, 8'd17, 8'd17, 8'd200, 8'd200, 8'd200, 1'b0}},
      '{'{8'd128, 8'd128, 8'd128, 8'd128, 1'b1}, 1'b1,
        '{8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 1'b1}},
      '{'{8'd0,   8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, '0},
      '{'{8'd255, 8'd255, 8'd255, 8'd255, 1'b1}, 1'b0, '0},
      '{'{8'd0,   8'd255, 8'd255, 8'd0,   1'b0}, 1'b0, '0},
      '{'{8'd255, 8'd0,   8'd0,   8'd255, 1'b0}, 1'b0, '0},
      // small negative sums must floor, not truncate toward zero
      '{'{8'd1,   8'd127, 8'd2,   8'd128, 1'b0}, 1'b0, '0},
      '{'{8'd128, 8'd129, 8'd128, 8'd127, 1'b0}, 1'b0, '0},
      '{'{8'd128, 8'd127, 8'd128, 8'd129, 1'b1}, 1'b0, '0},
      '{'{8'd255, 8'd255, 8'd0,   8'd255, 1'b0}, 1'b0, '0},
      '{'{8'd0,   8'd0,   8'd255, 8'd0,   1'b0}, 1'b0, '0},
      '{'{8'd200, 8'd60,  8'd40,  8'd230, 1'b0}, 1'b0, '0},
      '{'{8'd16,  8'd240, 8'd235, 8'd16,  1'b0}, 1'b0, '0},
      '{'{8'd85,  8'd170, 8'd170, 8'd85,  1'b0}, 1'b0, '0},
      '{'{8'd170, 8'd85,  8'd85,  8'd170, 1'b1}, 1'b0, '0}
   };

   yuyv_to_bgr24_converter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [PIX_W-1:0] clamp_q12(int sum);
      int v;
      v = sum >>> 12;
      if (v < 0) return '0;
      if (v > 255) return 8'd255;
      return v[PIX_W-1:0];
   endfunction

   function automatic rsp_type bgr_of_yuyv(req_type p);
      rsp_type o;
      int      db;
      int      dr;
      int      y0;
      int      y1;
      db = int'(p.chroma_blue) - 128;
      dr = int'(p.chroma_red) - 128;
      y0 = int'(p.luma_first) * 4096;
      y1 = int'(p.luma_second) * 4096;
      o.blue_first    = clamp_q12(y0 + Q12_BLUE_CB * db);
      o.green_first   = clamp_q12(y0 - Q12_GREEN_CB * db - Q12_GREEN_CR * dr);
      o.red_first     = clamp_q12(y0 + Q12_RED_CR * dr);
      o.blue_second   = clamp_q12(y1 + Q12_BLUE_CB * db);
      o.green_second  = clamp_q12(y1 - Q12_GREEN_CB * db - Q12_GREEN_CR * dr);
      o.red_second    = clamp_q12(y1 + Q12_RED_CR * dr);
      o.frame_end_out = p.frame_end_in;
      return o;
   endfunction

   // mostly uniform bytes, some pulled to the clamp and chroma-center corners
   function automatic logic [PIX_W-1:0] random_byte();
      logic [PIX_W-1:0] corners [7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
      if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 6)];
      return PIX_W'($urandom_range(0, 255));
   endfunction

   function automatic req_type random_yuyv();
      req_type p;
      p.luma_first   = random_byte();
      p.chroma_blue  = random_byte();
      p.luma_second  = random_byte();
      p.chroma_red   = random_byte();
      p.frame_end_in = ($urandom_range(0, 15) == 0);
      return p;
   endfunction

   // called at a rising edge; returns at the edge where the request is taken
   task automatic offer(req_type p, rsp_type want);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (!req_ready);
      pending_bgr.push_back(want);
   endtask

   task automatic check_field(string name, int expected, int actual);
      if (expected != actual) begin
         $error("%s expected %0d got %0d", name, expected, actual);
         errors++;
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type exp_bgr;
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            if (pending_bgr.size() == 0) begin
               $error("response with no request pending");
               errors++;
            end else begin
               exp_bgr = pending_bgr.pop_front();
               check_field("blue_first", int'(exp_bgr.blue_first),
                           int'(rsp_data.blue_first));
               check_field("green_first", int'(exp_bgr.green_first),
                           int'(rsp_data.green_first));
               check_field("red_first", int'(exp_bgr.red_first),
                           int'(rsp_data.red_first));
               check_field("blue_second", int'(exp_bgr.blue_second),
                           int'(rsp_data.blue_second));
               check_field("green_second", int'(exp_bgr.green_second),
                           int'(rsp_data.green_second));
               check_field("red_second", int'(exp_bgr.red_second),
                           int'(rsp_data.red_second));
               check_field("frame_end_out", int'(exp_bgr.frame_end_out),
                           int'(rsp_data.frame_end_out));
            end
         end
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      req_type p;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         p = directed_rows[i].pixels;
         offer(p, directed_rows[i].typed ? directed_rows[i].want : bgr_of_yuyv(p));
      end

      // sender pauses until the pipeline has drained
      req_valid <= 1'b0;
      while (pending_bgr.size() != 0) @(posedge clock);

      repeat (RANDOM_PER_PHASE) begin
         p = random_yuyv();
         offer(p, bgr_of_yuyv(p));
      end

      send_idle_pct = 65;
      recv_idle_pct = 24;
      repeat (RANDOM_PER_PHASE) begin
         p = random_yuyv();
         offer(p, bgr_of_yuyv(p));
      end

      // back-to-back requests against a long output stall fill the pipeline
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_request = 1'b1;
      repeat (RANDOM_PER_PHASE) begin
         p = random_yuyv();
         offer(p, bgr_of_yuyv(p));
      end
      req_valid <= 1'b0;

      while (pending_bgr.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== yuyv_to_bgr24_converter_unit.f =====
hw/rtl/yuyvbgr_pkg.sv
hw/rtl/yuyv_to_bgr24_converter_unit.sv
dv/testbench.sv
